>>> rtl/tscr_pkg.sv
// Shared types and constants for the texture slot cache.
`default_nettype none
package tscr_pkg;

    localparam int SLOT_COUNT_DEF = 128;
    localparam int KEY_BITS_DEF   = 32;
    localparam int IN_KEY_W       = 32;
    localparam int FRAME_W        = 32;
    localparam int OUTCOME_W      = 2;
    localparam int SLOT_IDX_W     = 7;

    localparam logic [OUTCOME_W-1:0] OUTCOME_HIT  = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUTCOME_FILL = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUTCOME_FULL = 2'd2;

    typedef struct packed {
        logic [IN_KEY_W-1:0] texture_key;
        logic [FRAME_W-1:0]  frame_number;
    } t_req;

    typedef struct packed {
        logic [OUTCOME_W-1:0]  outcome;
        logic [SLOT_IDX_W-1:0] slot_index;
    } t_rsp;

    typedef struct packed {
        logic match;
        logic stale;
    } t_probe;

endpackage
`default_nettype wire

>>> rtl/tscr_slot_mem.sv
// Slot tag and last-frame memories, one write port and one registered read port.
`default_nettype none
module tscr_slot_mem
    import tscr_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    localparam int IDX_W     = $clog2(SLOT_COUNT)
) (
    input  wire logic                i_clk,
    input  wire logic                i_wr_en,
    input  wire logic [IDX_W-1:0]    i_wr_addr,
    input  wire logic [KEY_BITS-1:0] i_wr_tag,
    input  wire logic [FRAME_W-1:0]  i_wr_frame,
    input  wire logic                i_rd_en,
    input  wire logic [IDX_W-1:0]    i_rd_addr,
    output logic      [KEY_BITS-1:0] o_rd_tag,
    output logic      [FRAME_W-1:0]  o_rd_frame
);

    logic [KEY_BITS-1:0] r_tags   [SLOT_COUNT];
    logic [FRAME_W-1:0]  r_frames [SLOT_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_tags[i_wr_addr]   <= i_wr_tag;
            r_frames[i_wr_addr] <= i_wr_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_tag   <= r_tags[i_rd_addr];
            o_rd_frame <= r_frames[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

>>> rtl/tscr_probe_unit.sv
// Shared probe unit: tag match and frame age test for one slot.
`default_nettype none
module tscr_probe_unit
    import tscr_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  wire logic [KEY_BITS-1:0] i_tag,
    input  wire logic [KEY_BITS-1:0] i_key,
    input  wire logic [FRAME_W-1:0]  i_last_frame,
    input  wire logic [FRAME_W-1:0]  i_frame,
    output t_probe                   o_probe
);

    logic [FRAME_W-1:0] age;

    always_comb begin
        age           = i_frame - i_last_frame;
        o_probe.match = (i_tag == i_key);
        o_probe.stale = !age[FRAME_W-1] && (age[FRAME_W-2:1] != '0);
    end

endmodule
`default_nettype wire

>>> rtl/texture_slot_cache_round_robin.sv
// Top level: sequencer driving the slot memory and the shared probe unit.
// A zero key goes straight to the result with no search; a hit ends the scan at its slot.
// A miss scans all SLOT_COUNT tags, then probes up to SLOT_COUNT slots for age, one slot
// per cycle through the single memory read port; the result then waits for the output to be free.
// One item at a time: ready is low while an item is in flight, until its result is queued.
// After reset a clearing pass zeroes every slot before ready rises.
`default_nettype none
module texture_slot_cache_round_robin
    import tscr_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_req i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_rsp      o_out_data
);

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOT_COUNT - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(SLOT_COUNT);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_AGE   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [IDX_W-1:0]    r_ptr, n_ptr;
    logic [IDX_W-1:0]    r_victim, n_victim;
    logic [CNT_W-1:0]    r_left, n_left;
    logic                r_chk_vld, n_chk_vld;
    logic [IDX_W-1:0]    r_chk_idx, n_chk_idx;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [FRAME_W-1:0]  r_frame, n_frame;
    t_rsp                r_res, n_res;
    logic                r_out_vld, n_out_vld;
    t_rsp                r_out, n_out;

    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [KEY_BITS-1:0] wr_tag;
    logic [FRAME_W-1:0]  wr_frame;
    logic                rd_en;
    logic [KEY_BITS-1:0] rd_tag;
    logic [FRAME_W-1:0]  rd_frame;
    t_probe              probe;

    logic [KEY_BITS+IN_KEY_W-1:0]  key_ext;
    logic [KEY_BITS-1:0]           key_in;
    logic [IDX_W+SLOT_IDX_W-1:0]   idx_ext;
    logic [SLOT_IDX_W-1:0]         chk_idx7;
    logic [IDX_W-1:0]              ptr_inc;
    logic [IDX_W-1:0]              victim_inc;

    tscr_slot_mem #(
        .SLOT_COUNT (SLOT_COUNT),
        .KEY_BITS   (KEY_BITS)
    ) u_mem (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_tag   (wr_tag),
        .i_wr_frame (wr_frame),
        .i_rd_en    (rd_en),
        .i_rd_addr  (r_ptr),
        .o_rd_tag   (rd_tag),
        .o_rd_frame (rd_frame)
    );

    tscr_probe_unit #(
        .KEY_BITS (KEY_BITS)
    ) u_probe (
        .i_tag        (rd_tag),
        .i_key        (r_key),
        .i_last_frame (rd_frame),
        .i_frame      (r_frame),
        .o_probe      (probe)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_comb begin
        key_ext    = {{KEY_BITS{1'b0}}, i_in_data.texture_key};
        key_in     = key_ext[KEY_BITS-1:0];
        idx_ext    = {{SLOT_IDX_W{1'b0}}, r_chk_idx};
        chk_idx7   = idx_ext[SLOT_IDX_W-1:0];
        ptr_inc    = (r_ptr == LAST_IDX) ? '0 : r_ptr + 1'b1;
        victim_inc = (r_victim == LAST_IDX) ? '0 : r_victim + 1'b1;
    end

    always_comb begin
        n_state   = r_state;
        n_ptr     = r_ptr;
        n_victim  = r_victim;
        n_left    = r_left;
        n_chk_vld = 1'b0;
        n_chk_idx = r_ptr;
        n_key     = r_key;
        n_frame   = r_frame;
        n_res     = r_res;
        n_out_vld = r_out_vld && !i_out_ready;
        n_out     = r_out;
        wr_en     = 1'b0;
        wr_addr   = r_chk_idx;
        wr_tag    = r_key;
        wr_frame  = r_frame;
        rd_en     = 1'b0;

        case (r_state)
            ST_CLEAR: begin
                wr_en    = 1'b1;
                wr_addr  = r_ptr;
                wr_tag   = '0;
                wr_frame = '0;
                n_ptr    = ptr_inc;
                if (r_ptr == LAST_IDX) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_key   = key_in;
                    n_frame = i_in_data.frame_number;
                    if (key_in == '0) begin
                        n_res.outcome    = OUTCOME_FULL;
                        n_res.slot_index = '0;
                        n_state          = ST_DONE;
                    end else begin
                        n_ptr   = '0;
                        n_left  = FULL_CNT;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                rd_en     = (r_left != '0);
                n_chk_vld = rd_en;
                if (rd_en) begin
                    n_ptr  = ptr_inc;
                    n_left = r_left - 1'b1;
                end
                if (r_chk_vld && probe.match) begin
                    wr_en            = 1'b1;
                    n_res.outcome    = OUTCOME_HIT;
                    n_res.slot_index = chk_idx7;
                    n_chk_vld        = 1'b0;
                    n_state          = ST_DONE;
                end else if (r_left == '0) begin
                    n_ptr     = victim_inc;
                    n_left    = FULL_CNT;
                    n_chk_vld = 1'b0;
                    n_state   = ST_AGE;
                end
            end
            ST_AGE: begin
                rd_en     = (r_left != '0);
                n_chk_vld = rd_en;
                if (rd_en) begin
                    n_ptr  = ptr_inc;
                    n_left = r_left - 1'b1;
                end
                if (r_chk_vld && probe.stale) begin
                    wr_en            = 1'b1;
                    n_victim         = r_chk_idx;
                    n_res.outcome    = OUTCOME_FILL;
                    n_res.slot_index = chk_idx7;
                    n_chk_vld        = 1'b0;
                    n_state          = ST_DONE;
                end else if (r_left == '0) begin
                    n_res.outcome    = OUTCOME_FULL;
                    n_res.slot_index = '0;
                    n_chk_vld        = 1'b0;
                    n_state          = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    n_out_vld = 1'b1;
                    n_out     = r_res;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_ptr     <= '0;
            r_victim  <= LAST_IDX;
            r_left    <= '0;
            r_chk_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ptr     <= n_ptr;
            r_victim  <= n_victim;
            r_left    <= n_left;
            r_chk_vld <= n_chk_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx <= n_chk_idx;
        r_key     <= n_key;
        r_frame   <= n_frame;
        r_res     <= n_res;
        r_out     <= n_out;
    end

`ifndef SYNTHESIS
    a_full_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.outcome == OUTCOME_FULL) |-> (o_out_data.slot_index == '0))
        else $error("no-free-slot beat carries a nonzero slot index");

    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN || r_state == ST_AGE) |-> (r_left <= FULL_CNT))
        else $error("probe count exceeds slot count");

    a_victim_follows_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_AGE && r_chk_vld && probe.stale) |=> (r_victim == $past(r_chk_idx)))
        else $error("victim pointer not left on the filled slot");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_DONE) |-> !wr_en)
        else $error("slot write outside a search");
`endif

endmodule
`default_nettype wire
